// File: sv/cbm_pkg.sv
`timescale 1ns / 1ps

package cbm_pkg;

   localparam int PRG_ADDR_BITS_DEFAULT = 19;
   localparam int CHR_ADDR_BITS_DEFAULT = 18;

   localparam logic [6:0] PRG_COUNT_RESET = 7'd4;
   localparam logic [8:0] CHR_COUNT_RESET = 9'd8;

   typedef enum logic [1:0] {
      KIND_CPU_WRITE = 2'd0,
      KIND_CPU_READ  = 2'd1,
      KIND_PPU       = 2'd2,
      KIND_SCANLINE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      TGT_NONE    = 2'd0,
      TGT_PRG_ROM = 2'd1,
      TGT_PRG_RAM = 2'd2,
      TGT_CHR     = 2'd3
   } target_type;

   // mapper register select: address bits {14,13,0} of a write at 0x8000 and up
   typedef enum logic [2:0] {
      REG_BANK_SELECT = 3'b000,
      REG_BANK_DATA   = 3'b001,
      REG_MIRROR      = 3'b010,
      REG_PROTECT     = 3'b011,
      REG_IRQ_LATCH   = 3'b100,
      REG_IRQ_RELOAD  = 3'b101,
      REG_IRQ_DISABLE = 3'b110,
      REG_IRQ_ENABLE  = 3'b111
   } reg_sel_type;

   typedef enum logic {
      CSR_PRG_BANK_COUNT = 1'b0,
      CSR_CHR_BANK_COUNT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [6:0] prg_bank_count;
      logic [8:0] chr_bank_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0][7:0] bank_regs;
      logic [7:0]      bank_select;
      logic            irq_pending;
      logic            mirror_mode;
   } map_state_type;

   typedef struct packed {
      logic irq_line;
      logic mirror_horizontal;
   } status_type;

endpackage

// File: sv/cbm_req_if.sv
`timescale 1ns / 1ps

interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] address;
   logic [7:0]  value;

   modport source (output valid, kind, address, value, input ready);
   modport sink (input valid, kind, address, value, output ready);
endinterface

// File: sv/cbm_rsp_if.sv
`timescale 1ns / 1ps

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  target;
   logic [18:0] mapped_offset;
   logic        irq_line;
   logic        mirror_horizontal;

   modport source (output valid, target, mapped_offset, irq_line, mirror_horizontal,
                   input ready);
   modport sink (input valid, target, mapped_offset, irq_line, mirror_horizontal,
                 output ready);
endinterface

// File: sv/cbm_csr.sv
`timescale 1ns / 1ps

module cbm_csr import cbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [6:0]    prg_count_ff, prg_count_in;
   logic [8:0]    chr_count_ff, chr_count_in;
   logic          wr_en;
   csr_index_type index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_index_type'(csr_paddr[2]);

   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      if (wr_en) begin
         unique case (index)
            CSR_PRG_BANK_COUNT: prg_count_in = csr_pwdata[6:0];
            CSR_CHR_BANK_COUNT: chr_count_in = csr_pwdata[8:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= PRG_COUNT_RESET;
         chr_count_ff <= CHR_COUNT_RESET;
      end else begin
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
      end
   end

   always_comb begin
      unique case (index)
         CSR_PRG_BANK_COUNT: csr_prdata = {25'd0, prg_count_ff};
         CSR_CHR_BANK_COUNT: csr_prdata = {23'd0, chr_count_ff};
      endcase
   end

   assign cfg.prg_bank_count = prg_count_ff;
   assign cfg.chr_bank_count = chr_count_ff;

endmodule

// File: sv/cbm_regs.sv
`timescale 1ns / 1ps

module cbm_regs import cbm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  kind_type      kind,
   input  logic [15:0]   address,
   input  logic [7:0]    value,
   output map_state_type state,
   output status_type    status_next
);

   logic [7:0][7:0] bank_regs_ff, bank_regs_in;
   logic [7:0]      bank_select_ff, bank_select_in;
   logic [7:0]      cnt_reload_ff, cnt_reload_in;
   logic [7:0]      irq_counter_ff, irq_counter_in;
   logic            irq_enabled_ff, irq_enabled_in;
   logic            irq_pending_ff, irq_pending_in;
   logic            mirror_ff, mirror_in;
   reg_sel_type     reg_sel;

   assign reg_sel = reg_sel_type'({address[14:13], address[0]});

   always_comb begin
      bank_regs_in   = bank_regs_ff;
      bank_select_in = bank_select_ff;
      cnt_reload_in  = cnt_reload_ff;
      irq_counter_in = irq_counter_ff;
      irq_enabled_in = irq_enabled_ff;
      irq_pending_in = irq_pending_ff;
      mirror_in      = mirror_ff;
      if (step) begin
         if (kind == KIND_CPU_WRITE && address[15]) begin
            unique case (reg_sel)
               REG_BANK_SELECT: bank_select_in = value;
               REG_BANK_DATA:   bank_regs_in[bank_select_ff[2:0]] = value;
               REG_MIRROR:      mirror_in = value[0];
               REG_PROTECT:     ;
               REG_IRQ_LATCH:   cnt_reload_in = value;
               REG_IRQ_RELOAD:  irq_counter_in = 8'd0;
               REG_IRQ_DISABLE: begin
                  irq_enabled_in = 1'b0;
                  irq_pending_in = 1'b0;
               end
               REG_IRQ_ENABLE:  irq_enabled_in = 1'b1;
            endcase
         end else if (kind == KIND_SCANLINE) begin
            irq_counter_in = (irq_counter_ff == 8'd0) ? cnt_reload_ff
                                                      : irq_counter_ff - 8'd1;
            if (irq_enabled_ff && irq_counter_in == 8'd0) begin
               irq_pending_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_regs_ff   <= '0;
         bank_select_ff <= 8'd0;
         cnt_reload_ff  <= 8'd0;
         irq_counter_ff <= 8'd0;
         irq_enabled_ff <= 1'b0;
         irq_pending_ff <= 1'b0;
         mirror_ff      <= 1'b1;
      end else begin
         bank_regs_ff   <= bank_regs_in;
         bank_select_ff <= bank_select_in;
         cnt_reload_ff  <= cnt_reload_in;
         irq_counter_ff <= irq_counter_in;
         irq_enabled_ff <= irq_enabled_in;
         irq_pending_ff <= irq_pending_in;
         mirror_ff      <= mirror_in;
      end
   end

   assign state.bank_regs   = bank_regs_ff;
   assign state.bank_select = bank_select_ff;
   assign state.irq_pending = irq_pending_ff;
   assign state.mirror_mode = mirror_ff;

   assign status_next.irq_line          = irq_pending_in;
   assign status_next.mirror_horizontal = mirror_in;

endmodule

// File: sv/cbm_xlate.sv
`timescale 1ns / 1ps

module cbm_xlate import cbm_pkg::*; #(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT,
   parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEFAULT
) (
   input  kind_type      kind,
   input  logic [15:0]   address,
   input  map_state_type state,
   input  cfg_type       cfg,
   output target_type    target,
   output logic [18:0]   mapped_offset
);

   localparam logic [19:0] PRG_MASK = (20'd1 << PRG_ADDR_BITS) - 20'd1;
   localparam logic [18:0] CHR_MASK = (19'd1 << CHR_ADDR_BITS) - 19'd1;

   logic [6:0]  prg_mask, prg_last, prg_second, prg_bank;
   logic        prg_swap;
   logic [19:0] prg_full;
   logic [2:0]  chr_slot;
   logic [7:0]  chr_bank;
   logic [8:0]  chr_mask;
   logic [18:0] chr_full;
   logic [18:0] ram_offset;

   // PRG: four 8 KB slots, slot 3 fixed to the last bank
   always_comb begin
      prg_mask   = cfg.prg_bank_count - 7'd1;
      prg_last   = prg_mask;
      prg_second = cfg.prg_bank_count - 7'd2;
      prg_swap   = state.bank_select[6];
      unique case (address[14:13])
         2'd0:    prg_bank = prg_swap ? prg_second : state.bank_regs[6][6:0];
         2'd1:    prg_bank = state.bank_regs[7][6:0];
         2'd2:    prg_bank = prg_swap ? state.bank_regs[6][6:0] : prg_second;
         default: prg_bank = prg_last;
      endcase
      prg_full = {prg_bank & prg_mask, address[12:0]} & PRG_MASK;
   end

   // CHR: 2 KB pairs from registers 0/1, 1 KB from 2..5; bit 7 swaps halves
   always_comb begin
      chr_slot = address[12:10] ^ {state.bank_select[7], 2'b00};
      if (!chr_slot[2]) begin
         chr_bank = {state.bank_regs[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
      end else begin
         chr_bank = state.bank_regs[3'd2 + {1'b0, chr_slot[1:0]}];
      end
      chr_mask = cfg.chr_bank_count - 9'd1;
      chr_full = {{1'b0, chr_bank} & chr_mask, address[9:0]} & CHR_MASK;
   end

   assign ram_offset = {6'd0, address[12:0]};

   always_comb begin
      target        = TGT_NONE;
      mapped_offset = 19'd0;
      unique case (kind)
         KIND_CPU_WRITE: begin
            if (!address[15] && address[14:13] == 2'b11) begin
               target        = TGT_PRG_RAM;
               mapped_offset = ram_offset;
            end
         end
         KIND_CPU_READ: begin
            if (address[15]) begin
               target        = TGT_PRG_ROM;
               mapped_offset = prg_full[18:0];
            end else if (address[14:13] == 2'b11) begin
               target        = TGT_PRG_RAM;
               mapped_offset = ram_offset;
            end
         end
         KIND_PPU: begin
            target        = TGT_CHR;
            mapped_offset = chr_full;
         end
         KIND_SCANLINE: ;
      endcase
   end

endmodule

// File: sv/cartridge_bank_mapper_scanline_irq_core.sv
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register moves on into the result register,
// and its result transaction completes from there.
// Throughput: one transaction per cycle; a result held off stalls the input only
// once the input register is also occupied.
// Reset: synchronous, active high; bank counts return to 4 and 8, mirroring to horizontal.

module cartridge_bank_mapper_scanline_irq_core import cbm_pkg::*; #(
   parameter int PRG_ADDR_BITS = PRG_ADDR_BITS_DEFAULT,
   parameter int CHR_ADDR_BITS = CHR_ADDR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cbm_req_if.sink     req_chan,
   cbm_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic          s1_valid_ff, s1_valid_in;
   kind_type      s1_kind_ff;
   logic [15:0]   s1_addr_ff;
   logic [7:0]    s1_value_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   target_type    rsp_target_ff;
   logic [18:0]   rsp_offset_ff;
   status_type    rsp_status_ff;
   logic          advance;
   logic          req_take;
   cfg_type       cfg;
   map_state_type state;
   status_type    status_next;
   target_type    target;
   logic [18:0]   mapped_offset;

   cbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .kind        (s1_kind_ff),
      .address     (s1_addr_ff),
      .value       (s1_value_ff),
      .state       (state),
      .status_next (status_next)
   );

   cbm_xlate #(
      .PRG_ADDR_BITS (PRG_ADDR_BITS),
      .CHR_ADDR_BITS (CHR_ADDR_BITS)
   ) u_xlate (
      .kind          (s1_kind_ff),
      .address       (s1_addr_ff),
      .state         (state),
      .cfg           (cfg),
      .target        (target),
      .mapped_offset (mapped_offset)
   );

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= kind_type'(req_chan.kind);
         s1_addr_ff  <= req_chan.address;
         s1_value_ff <= req_chan.value;
      end
      if (advance) begin
         rsp_target_ff <= target;
         rsp_offset_ff <= mapped_offset;
         rsp_status_ff <= status_next;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.target            = rsp_target_ff;
   assign rsp_chan.mapped_offset     = rsp_offset_ff;
   assign rsp_chan.irq_line          = rsp_status_ff.irq_line;
   assign rsp_chan.mirror_horizontal = rsp_status_ff.mirror_horizontal;

   // a transaction leaving the input register always lands in the result register
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not filled after advance");

   // the IRQ flag is only raised by a scanline tick
   a_irq_from_scanline: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(state.irq_pending)) |->
         $past(advance && s1_kind_ff == KIND_SCANLINE))
      else $error("irq pending raised without a scanline tick");

   // mirroring only changes on a CPU write
   a_mirror_from_write: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(state.mirror_mode)) |->
         $past(advance && s1_kind_ff == KIND_CPU_WRITE))
      else $error("mirroring changed without a CPU write");

endmodule

// File: tb/cartridge_bank_mapper_scanline_irq_core_tb.sv
`timescale 1ns / 1ps

module cartridge_bank_mapper_scanline_irq_core_tb;
   import cbm_pkg::*;

   typedef struct packed {
      target_type  target;
      logic [18:0] offset;
      logic        irq;
      logic        mirror;
   } map_result_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cbm_req_if req_bus ();
   cbm_rsp_if rsp_bus ();

   cartridge_bank_mapper_scanline_irq_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mapper shadow state
   logic [6:0] prg_count;
   logic [8:0] chr_count;
   logic [7:0] banks [8];
   logic [7:0] bank_sel;
   logic [7:0] line_reload;
   logic [7:0] irq_counter;
   logic       irq_en;
   logic       irq_pend;
   logic       mirror_h;

   map_result_type expected_maps[$];

   int errors;
   int items_sent;
   int results_seen;
   int irq_raises;
   int settings_run;
   int hold_req;
   bit no_idle;

   always #2 clock = ~clock;

   initial begin
      #(2_000_000);
      $display("FAIL cartridge_bank_mapper_scanline_irq_core");
      $finish;
   end

   function automatic void shadow_reset();
      prg_count   = PRG_COUNT_RESET;
      chr_count   = CHR_COUNT_RESET;
      foreach (banks[i]) banks[i] = 8'h00;
      bank_sel    = 8'h00;
      line_reload = 8'h00;
      irq_counter = 8'h00;
      irq_en      = 1'b0;
      irq_pend    = 1'b0;
      mirror_h    = 1'b1;
   endfunction

   function automatic logic [18:0] prg_translate(logic [15:0] a);
      logic [31:0] mask;
      logic [31:0] second;
      logic [31:0] bank;
      mask   = (32'(prg_count) - 32'd1) & 32'h7F;
      second = (32'(prg_count) - 32'd2) & 32'h7F;
      case (a[14:13])
         2'd0: bank = bank_sel[6] ? second : 32'(banks[6]);
         2'd1: bank = 32'(banks[7]);
         2'd2: bank = bank_sel[6] ? 32'(banks[6]) : second;
         default: bank = mask;
      endcase
      bank &= mask;
      return 19'((bank << 13) | 32'(a[12:0]));
   endfunction

   function automatic logic [18:0] chr_translate(logic [15:0] a);
      logic [2:0]  slot;
      logic [31:0] bank;
      // bank select bit 7 swaps the 4 KB halves
      slot = a[12:10] ^ {bank_sel[7], 2'b00};
      if (!slot[2])
         bank = 32'({banks[{2'b00, slot[1]}][7:1], slot[0]});
      else
         bank = 32'(banks[3'd2 + {1'b0, slot[1:0]}]);
      bank &= (32'(chr_count) - 32'd1) & 32'h1FF;
      return 19'(((bank << 10) | 32'(a[9:0])) & 32'h3FFFF);
   endfunction

   function automatic map_result_type map_step(kind_type k, logic [15:0] a, logic [7:0] v);
      map_result_type res;
      logic           was_pending;
      res.target  = TGT_NONE;
      res.offset  = '0;
      was_pending = irq_pend;
      case (k)
         KIND_CPU_WRITE, KIND_CPU_READ: begin
            if (a[15] && k == KIND_CPU_WRITE) begin
               case (reg_sel_type'({a[14], a[13], a[0]}))
                  REG_BANK_SELECT: bank_sel = v;
                  REG_BANK_DATA:   banks[bank_sel[2:0]] = v;
                  REG_MIRROR:      mirror_h = v[0];
                  REG_PROTECT:     ;
                  REG_IRQ_LATCH:   line_reload = v;
                  REG_IRQ_RELOAD:  irq_counter = 8'h00;
                  REG_IRQ_DISABLE: begin
                     irq_en   = 1'b0;
                     irq_pend = 1'b0;
                  end
                  default:         irq_en = 1'b1;
               endcase
            end else if (a[15]) begin
               res.target = TGT_PRG_ROM;
               res.offset = prg_translate(a);
            end else if (a >= 16'h6000) begin
               res.target = TGT_PRG_RAM;
               res.offset = 19'(a - 16'h6000);
            end
         end
         KIND_PPU: begin
            res.target = TGT_CHR;
            res.offset = chr_translate(a);
         end
         default: begin
            if (irq_counter == 8'h00)
               irq_counter = line_reload;
            else
               irq_counter = irq_counter - 8'd1;
            if (irq_en && irq_counter == 8'h00)
               irq_pend = 1'b1;
         end
      endcase
      if (irq_pend && !was_pending)
         irq_raises++;
      res.irq    = irq_pend;
      res.mirror = mirror_h;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
         errors++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      map_result_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_maps.size() == 0) begin
            $display("%0t ns: unexpected transaction, actual target %0d offset 0x%0h",
                     $time, rsp_bus.target, rsp_bus.mapped_offset);
            errors++;
         end else begin
            exp = expected_maps.pop_front();
            check_field("target", 32'(exp.target), 32'(rsp_bus.target));
            check_field("mapped_offset", 32'(exp.offset), 32'(rsp_bus.mapped_offset));
            check_field("irq_line", 32'(exp.irq), 32'(rsp_bus.irq_line));
            check_field("mirror_horizontal", 32'(exp.mirror), 32'(rsp_bus.mirror_horizontal));
         end
      end
   end

   // result-side flow control; hold_req asks for one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            stall_left = hold_req;
            hold_req   = 0;
         end
         if (stall_left == 0 && !no_idle && $urandom_range(0, 99) < 25)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic int idle_len();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   task automatic send_txn(kind_type k, logic [15:0] a, logic [7:0] v);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= k;
      req_bus.address <= a;
      req_bus.value   <= v;
      do @(posedge clock); while (!req_bus.ready);
      expected_maps.push_back(map_step(k, a, v));
      items_sent++;
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] data);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_PRG_BANK_COUNT)
         prg_count = data[6:0];
      else
         chr_count = data[8:0];
      // read it back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = (idx == CSR_PRG_BANK_COUNT) ? 32'(prg_count) : 32'(chr_count);
      check_field("csr readback", readback, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_counts(int prg, int chr);
      drain();
      csr_write(CSR_PRG_BANK_COUNT, 32'(prg));
      csr_write(CSR_CHR_BANK_COUNT, 32'(chr));
      settings_run++;
   endtask

   function automatic logic [15:0] reg_addr(reg_sel_type r);
      logic [15:0] a;
      a     = 16'($urandom);
      a[15] = 1'b1;
      a[14] = r[2];
      a[13] = r[1];
      a[0]  = r[0];
      return a;
   endfunction

   task automatic rand_txn();
      int r;
      r = $urandom_range(0, 99);
      if (r < 22)
         send_txn(KIND_CPU_WRITE, 16'($urandom) | 16'h8000, 8'($urandom));
      else if (r < 30)
         send_txn(KIND_CPU_WRITE, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      else if (r < 58)
         send_txn(KIND_CPU_READ, 16'($urandom), 8'($urandom));
      else if (r < 82)
         send_txn(KIND_PPU, 16'($urandom), 8'($urandom));
      else
         send_txn(KIND_SCANLINE, 16'($urandom), 8'($urandom));
   endtask

   task automatic bank_program();
      send_txn(KIND_CPU_WRITE, reg_addr(REG_BANK_SELECT), 8'($urandom));
      send_txn(KIND_CPU_WRITE, reg_addr(REG_BANK_DATA), 8'($urandom));
      repeat ($urandom_range(2, 6))
         send_txn($urandom_range(0, 1) ? KIND_CPU_READ : KIND_PPU, 16'($urandom), 8'($urandom));
   endtask

   // latch, reload, enable or disable, then enough scanlines to reach zero
   task automatic irq_run();
      logic [7:0] lat;
      int         n;
      lat = 8'($urandom_range(0, 6));
      send_txn(KIND_CPU_WRITE, reg_addr(REG_IRQ_LATCH), lat);
      send_txn(KIND_CPU_WRITE, reg_addr(REG_IRQ_RELOAD), 8'($urandom));
      send_txn(KIND_CPU_WRITE,
               reg_addr(($urandom_range(0, 3) == 0) ? REG_IRQ_DISABLE : REG_IRQ_ENABLE),
               8'($urandom));
      n = int'(lat) + $urandom_range(1, 4);
      repeat (n) begin
         send_txn(KIND_SCANLINE, 16'($urandom), 8'($urandom));
         if ($urandom_range(0, 2) == 0)
            rand_txn();
      end
      if ($urandom_range(0, 1))
         send_txn(KIND_CPU_WRITE, reg_addr(REG_IRQ_DISABLE), 8'($urandom));
   endtask

   task automatic run_random(int n);
      int start;
      start = items_sent;
      while (items_sent - start < n) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: bank_program();
            4, 5:       irq_run();
            default:    rand_txn();
         endcase
      end
   endtask

   // reset bank counts, address extremes, every register, irq with a zero latch
   task automatic test_directed();
      send_txn(KIND_CPU_WRITE, 16'h8000, 8'hC6);
      send_txn(KIND_CPU_WRITE, 16'h8001, 8'hFF);
      send_txn(KIND_CPU_READ,  16'h8000, 8'h00);
      send_txn(KIND_CPU_READ,  16'hA000, 8'h00);
      send_txn(KIND_CPU_READ,  16'hC000, 8'h00);
      send_txn(KIND_CPU_READ,  16'hFFFF, 8'hFF);
      send_txn(KIND_PPU,       16'h0000, 8'h00);
      send_txn(KIND_PPU,       16'h1FFF, 8'h00);
      send_txn(KIND_PPU,       16'hFFFF, 8'hFF);
      send_txn(KIND_CPU_WRITE, 16'h8000, 8'h00);
      send_txn(KIND_CPU_WRITE, 16'h8001, 8'hFE);
      send_txn(KIND_PPU,       16'h0400, 8'h00);
      send_txn(KIND_CPU_READ,  16'h0000, 8'h00);
      send_txn(KIND_CPU_READ,  16'h5FFF, 8'h00);
      send_txn(KIND_CPU_READ,  16'h6000, 8'h00);
      send_txn(KIND_CPU_WRITE, 16'h7FFF, 8'h55);
      send_txn(KIND_CPU_WRITE, 16'h4000, 8'h12);
      send_txn(KIND_CPU_WRITE, 16'hA000, 8'h00);
      send_txn(KIND_CPU_WRITE, 16'hA001, 8'hFF);
      send_txn(KIND_CPU_WRITE, 16'hC000, 8'h00);
      send_txn(KIND_CPU_WRITE, 16'hC001, 8'h00);
      send_txn(KIND_CPU_WRITE, 16'hE001, 8'h00);
      send_txn(KIND_SCANLINE,  16'h0000, 8'h00);
      send_txn(KIND_CPU_WRITE, 16'hE000, 8'h00);
      send_txn(KIND_SCANLINE,  16'hFFFF, 8'hFF);
   endtask

   task automatic test_bank_counts();
      int prg_vals [6] = '{2, 64, 8, 6, 32, 16};
      int chr_vals [6] = '{1, 256, 32, 3, 128, 2};
      foreach (prg_vals[i]) begin
         set_counts(prg_vals[i], chr_vals[i]);
         no_idle = (i % 3 == 2);
         run_random(190);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_irq_runs();
      set_counts(4, 8);
      repeat (12) irq_run();
   endtask

   task automatic test_backpressure();
      drain();
      hold_req = 300;
      no_idle  = 1'b1;
      repeat (40) rand_txn();
      no_idle  = 1'b0;
      // sender waits for every outstanding result before going on
      drain();
      run_random(60);
   endtask

   initial begin
      clock        = 1'b0;
      errors       = 0;
      items_sent   = 0;
      results_seen = 0;
      irq_raises   = 0;
      settings_run = 1;
      hold_req     = 0;
      no_idle      = 1'b0;
      shadow_reset();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= KIND_CPU_WRITE;
      req_bus.address <= '0;
      req_bus.value   <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_bank_counts();
      test_irq_runs();
      test_backpressure();
      drain();
      repeat (10) @(posedge clock);

      $display("Ran %0d transactions over %0d bank-count settings, %0d results checked,",
               items_sent, settings_run, results_seen);
      $display("irq raised %0d times, one long result hold-off included.", irq_raises);
      if (errors == 0)
         $display("PASS cartridge_bank_mapper_scanline_irq_core");
      else
         $display("FAIL cartridge_bank_mapper_scanline_irq_core");
      $finish;
   end

endmodule

// File: filelist.f
sv/cbm_pkg.sv
sv/cbm_req_if.sv
sv/cbm_rsp_if.sv
sv/cbm_csr.sv
sv/cbm_regs.sv
sv/cbm_xlate.sv
sv/cartridge_bank_mapper_scanline_irq_core.sv
tb/cartridge_bank_mapper_scanline_irq_core_tb.sv
